### hw/rtl/sobel_pkg.sv
// ============================================================================
// Sobel edge magnitude package
// Shared widths and the word types that pass from the front end to the window stage and on to the back end.
// ============================================================================
package sobel_pkg;
    localparam int MaxWidth   = 1024;
    localparam int MaxHeight  = 4096;
    localparam int ColW       = $clog2(MaxWidth);
    localparam int RowW       = $clog2(MaxHeight) + 1;
    localparam int LwW        = 11;
    localparam int FhW        = 13;
    localparam int CfgDataW   = 13;
    localparam int CfgIdxW    = 1;
    localparam int PixW       = 24;
    localparam int QDepth     = 4;
    localparam int QPtrW      = $clog2(QDepth);

    localparam logic [CfgIdxW-1:0] RegLineWidth   = 1'b0;
    localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;

    typedef struct packed {
        logic [PixW-1:0] pix;
        logic [ColW-1:0] col;
        logic            emit;
    } fe_word_t;

    typedef struct packed {
        logic [PixW-1:0] win0;
        logic [PixW-1:0] win1;
        logic [PixW-1:0] win2;
        logic [PixW-1:0] win3;
        logic [PixW-1:0] win4;
        logic [PixW-1:0] win5;
        logic [PixW-1:0] win6;
        logic [PixW-1:0] win7;
        logic [PixW-1:0] win8;
        logic [8:0]      mask;
        logic            last;
    } win_word_t;
endpackage

### hw/rtl/sobel_front.sv
// ============================================================================
// Sobel front end
// Accepts words, filters them by frame position, and queues the words it uses, drain words as zero pixels.
// ============================================================================
module sobel_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     restart,
    input  logic [sobel_pkg::RowW-1:0] eff_h,
    input  logic [sobel_pkg::ColW:0]   eff_w,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_req_type,
    input  logic [7:0]               s_red_in,
    input  logic [7:0]               s_green_in,
    input  logic [7:0]               s_blue_in,
    output logic                     q_valid,
    input  logic                     q_ready,
    output sobel_pkg::fe_word_t      q_word
);
    import sobel_pkg::*;

    logic [ColW-1:0]  col_reg;
    logic [RowW-1:0]  row_reg;
    fe_word_t         mem_reg [QDepth];
    logic [QPtrW-1:0] wp_reg, rp_reg;
    logic [QPtrW:0]   cnt_reg;
    logic             frame_in, take, use_it, push, pop, frame_end;
    fe_word_t         w;

    assign s_ready  = (cnt_reg != QDepth[QPtrW:0]);
    assign take     = s_valid && s_ready;
    assign frame_in = (row_reg >= eff_h);
    assign use_it   = take && (s_req_type ? frame_in : !frame_in);
    assign push     = use_it;
    assign pop      = q_valid && q_ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_word   = mem_reg[rp_reg];
    // The final result of a frame comes with the first word of the second drain row.
    assign frame_end = use_it && (row_reg == eff_h + 1'b1) && (col_reg == '0);

    always_comb begin
        w.pix  = s_req_type ? '0 : {s_red_in, s_green_in, s_blue_in};
        w.col  = col_reg;
        w.emit = (row_reg >= RowW'(2)) || (row_reg == RowW'(1) && col_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= w;
        end
        if (!aresetn || restart || frame_end) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (use_it) begin
            if ({1'b0, col_reg} + 1'b1 >= eff_w) begin
                col_reg <= '0;
                row_reg <= row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
        if (!aresetn || restart) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {{QPtrW{1'b0}}, push} - {{QPtrW{1'b0}}, pop};
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == QDepth[QPtrW:0] |-> !push) else $error("queue overflow");
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn || restart)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("count");
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != '0) else $error("queue underflow");
endmodule

### hw/rtl/sobel_window.sv
// ============================================================================
// Sobel window stage
// Line stores and the 3x3 window; emits window words with border masks.
// ============================================================================
module sobel_window (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       restart,
    input  logic [sobel_pkg::RowW-1:0] eff_h,
    input  logic [sobel_pkg::ColW:0]   eff_w,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  sobel_pkg::fe_word_t        q_word,
    output logic                       w_valid,
    input  logic                       w_ready,
    output sobel_pkg::win_word_t       w_word
);
    import sobel_pkg::*;

    logic [PixW-1:0] up_mem [MaxWidth];
    logic [PixW-1:0] lo_mem [MaxWidth];
    logic [PixW-1:0] up_rd_reg, lo_rd_reg;
    logic [PixW-1:0] win_reg [9];
    logic [PixW-1:0] pix_reg;
    logic            s1_valid_reg, s1_emit_reg;
    logic [ColW-1:0] wcol_reg;
    logic            wr_pend_reg;
    logic [ColW-1:0] ocol_reg;
    logic [RowW-1:0] orow_reg;
    logic            wv_reg;
    win_word_t       ww_reg;
    logic            adv1, adv2, last, top, bot, lft, rgt, frame_done;

    // Stage 1 reads the line stores; stage 2 shifts the window and emits.
    assign adv2    = s1_valid_reg && (!wv_reg || w_ready);
    assign q_ready = !s1_valid_reg || adv2;
    assign adv1    = q_valid && q_ready;
    assign w_valid = wv_reg;
    assign w_word  = ww_reg;

    assign top  = (orow_reg == '0);
    assign bot  = (orow_reg + 1'b1 >= eff_h);
    assign lft  = (ocol_reg == '0);
    assign rgt  = ({1'b0, ocol_reg} + 1'b1 >= eff_w);
    assign last = bot && rgt;
    assign frame_done = adv2 && s1_emit_reg && last;

    always_ff @(posedge aclk) begin
        if (adv1) begin
            // A read right behind a pending write to the same column takes the new word.
            up_rd_reg <= (wr_pend_reg && wcol_reg == q_word.col) ? lo_rd_reg
                                                                 : up_mem[q_word.col];
            lo_rd_reg <= lo_mem[q_word.col];
            lo_mem[q_word.col] <= q_word.pix;
            wcol_reg    <= q_word.col;
            pix_reg     <= q_word.pix;
            s1_emit_reg <= q_word.emit;
        end
        // The upper store takes the old lower-store word in the cycle after the read.
        if (wr_pend_reg) begin
            up_mem[wcol_reg] <= lo_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pend_reg <= 1'b0;
        end else begin
            wr_pend_reg <= adv1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            s1_valid_reg <= 1'b0;
            wv_reg       <= 1'b0;
            ocol_reg     <= '0;
            orow_reg     <= '0;
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
        end else begin
            if (adv1) s1_valid_reg <= 1'b1;
            else if (adv2) s1_valid_reg <= 1'b0;
            if (w_ready) wv_reg <= 1'b0;
            if (adv2) begin
                if (s1_emit_reg && last) begin
                    for (int i = 0; i < 9; i++) win_reg[i] <= '0;
                    ocol_reg <= '0;
                    orow_reg <= '0;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        win_reg[i*3]   <= win_reg[i*3+1];
                        win_reg[i*3+1] <= win_reg[i*3+2];
                    end
                    win_reg[2] <= up_rd_reg;
                    win_reg[5] <= lo_rd_reg;
                    win_reg[8] <= pix_reg;
                    if (s1_emit_reg) begin
                        if (rgt) begin
                            ocol_reg <= '0;
                            orow_reg <= orow_reg + 1'b1;
                        end else begin
                            ocol_reg <= ocol_reg + 1'b1;
                        end
                    end
                end
                if (s1_emit_reg) begin
                    wv_reg      <= 1'b1;
                    ww_reg.win0 <= win_reg[1];
                    ww_reg.win1 <= win_reg[2];
                    ww_reg.win2 <= up_rd_reg;
                    ww_reg.win3 <= win_reg[4];
                    ww_reg.win4 <= win_reg[5];
                    ww_reg.win5 <= lo_rd_reg;
                    ww_reg.win6 <= win_reg[7];
                    ww_reg.win7 <= win_reg[8];
                    ww_reg.win8 <= pix_reg;
                    ww_reg.mask <= {!bot && !rgt, !bot, !bot && !lft,
                                    !rgt, 1'b1, !lft,
                                    !top && !rgt, !top, !top && !lft};
                    ww_reg.last <= last;
                end
            end
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn || restart)
        (wv_reg && !w_ready) |=> wv_reg) else $error("window word dropped");
    a_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        adv2 |-> s1_valid_reg) else $error("advance without data");
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |-> s1_emit_reg) else $error("frame end without result");
endmodule

### hw/rtl/sobel_mag.sv
// ============================================================================
// Sobel magnitude back end
// Gradients per channel, then an 8-step pipelined floor square root.
// ============================================================================
module sobel_mag (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 restart,
    input  logic                 w_valid,
    output logic                 w_ready,
    input  sobel_pkg::win_word_t w_word,
    output logic                 f_valid,
    input  logic                 f_ready,
    output logic [7:0]           f_red,
    output logic [7:0]           f_green,
    output logic [7:0]           f_blue,
    output logic [20:0]          f_sr,
    output logic [20:0]          f_sg,
    output logic [20:0]          f_sb,
    output logic                 f_last
);
    import sobel_pkg::*;

    localparam int NStg = 10;

    logic            v_reg   [NStg];
    logic            l_reg   [NStg];
    logic [20:0]     s_reg   [NStg][3];
    logic [7:0]      r_reg   [NStg][3];
    logic            adv;
    logic [7:0]      px [9][3];
    logic [PixW-1:0] wp [9];

    // Stall the whole pipeline when the output stage is full and f_ready is low.
    assign adv     = !v_reg[NStg-1] || f_ready;
    assign w_ready = adv;
    assign f_valid = v_reg[NStg-1];
    assign f_red   = r_reg[NStg-1][0];
    assign f_green = r_reg[NStg-1][1];
    assign f_blue  = r_reg[NStg-1][2];
    assign f_sr    = s_reg[NStg-1][0];
    assign f_sg    = s_reg[NStg-1][1];
    assign f_sb    = s_reg[NStg-1][2];
    assign f_last  = l_reg[NStg-1];

    always_comb begin
        wp[0] = w_word.win0; wp[1] = w_word.win1; wp[2] = w_word.win2;
        wp[3] = w_word.win3; wp[4] = w_word.win4; wp[5] = w_word.win5;
        wp[6] = w_word.win6; wp[7] = w_word.win7; wp[8] = w_word.win8;
        for (int k = 0; k < 9; k++) begin
            for (int c = 0; c < 3; c++) begin
                px[k][c] = w_word.mask[k] ? wp[k][23-8*c -: 8] : 8'd0;
            end
        end
    end

    logic signed [11:0] gx_reg [3], gy_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            for (int i = 0; i < NStg; i++) v_reg[i] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= w_valid;
            for (int i = 1; i < NStg; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        logic [7:0]  t;
        logic [16:0] sq;
        logic signed [21:0] gxe, gye;
        if (adv) begin
            l_reg[0] <= w_word.last;
            for (int c = 0; c < 3; c++) begin
                gx_reg[c] <= 12'(signed'({4'd0, px[2][c]})) + 12'(signed'({3'd0, px[5][c], 1'b0}))
                           + 12'(signed'({4'd0, px[8][c]})) - 12'(signed'({4'd0, px[0][c]}))
                           - 12'(signed'({3'd0, px[3][c], 1'b0})) - 12'(signed'({4'd0, px[6][c]}));
                gy_reg[c] <= 12'(signed'({4'd0, px[6][c]})) + 12'(signed'({3'd0, px[7][c], 1'b0}))
                           + 12'(signed'({4'd0, px[8][c]})) - 12'(signed'({4'd0, px[0][c]}))
                           - 12'(signed'({3'd0, px[1][c], 1'b0})) - 12'(signed'({4'd0, px[2][c]}));
            end
            l_reg[1] <= l_reg[0];
            for (int c = 0; c < 3; c++) begin
                gxe = 22'(gx_reg[c]);
                gye = 22'(gy_reg[c]);
                s_reg[1][c] <= 21'(gxe * gxe) + 21'(gye * gye);
                r_reg[1][c] <= '0;
            end
            // One result bit per stage, most significant first.
            for (int i = 2; i < NStg; i++) begin
                l_reg[i] <= l_reg[i-1];
                for (int c = 0; c < 3; c++) begin
                    t  = r_reg[i-1][c] | (8'd1 << (NStg - 1 - i));
                    sq = 17'(t) * 17'(t);
                    s_reg[i][c] <= s_reg[i-1][c];
                    r_reg[i][c] <= (sq <= s_reg[i-1][c]) ? t : r_reg[i-1][c];
                end
            end
        end
    end

    a_last_valid: assert property (@(posedge aclk) disable iff (!aresetn || restart)
        (f_valid && !f_ready) |=> f_valid) else $error("result dropped");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !f_valid |-> w_ready) else $error("stalled while empty");
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn || restart)
        (f_valid && !f_ready) |=> $stable(f_red)) else $error("output moved");
endmodule

### hw/rtl/sobel_round.sv
// ============================================================================
// Sobel rounding stage
// Rounds the floor root to nearest and holds the result word for the output.
// ============================================================================
module sobel_round (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_r,
    input  logic [7:0] in_g,
    input  logic [7:0] in_b,
    input  logic [20:0] in_sr,
    input  logic [20:0] in_sg,
    input  logic [20:0] in_sb,
    input  logic       in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_red_out,
    output logic [7:0] m_green_out,
    output logic [7:0] m_blue_out,
    output logic       m_last_pixel
);
    logic       v_reg;
    logic [7:0] r_reg, g_reg, b_reg;
    logic       l_reg;

    function automatic logic [7:0] rnd(input logic [7:0] f, input logic [20:0] s);
        logic [16:0] th;
        th = 17'(f) * 17'(f) + 17'(f);
        return (s > 21'(th) && f != 8'hFF) ? f + 1'b1 : f;
    endfunction

    assign in_ready = !v_reg || m_ready;
    assign m_valid = v_reg;
    assign m_red_out = r_reg;
    assign m_green_out = g_reg;
    assign m_blue_out = b_reg;
    assign m_last_pixel = l_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            r_reg <= rnd(in_r, in_sr);
            g_reg <= rnd(in_g, in_sg);
            b_reg <= rnd(in_b, in_sb);
            l_reg <= in_last;
        end
    end
endmodule

### hw/rtl/sobel_edge_magnitude_rgb_top.sv
// ============================================================================
// Sobel edge magnitude, RGB
// Streaming 3x3 Sobel gradient magnitude per color channel.
// ============================================================================
// One word is accepted per clock while the front queue has room. Each result
// leaves line_width+1 words after its pixel, and m_valid rises once the word
// completing it has passed the front queue, the window stage registers, the
// gradient and square registers, the square root steps and the rounding
// register. Send line_width+1 drain words after the last pixel of a frame;
// last_pixel marks the final result.
module sobel_edge_magnitude_rgb_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_red_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_blue_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red_out,
    output logic [7:0]  m_green_out,
    output logic [7:0]  m_blue_out,
    output logic        m_last_pixel
);
    import sobel_pkg::*;

    logic [LwW-1:0]  lw_reg;
    logic [FhW-1:0]  fh_reg;
    logic [ColW:0]   eff_w;
    logic [RowW-1:0] eff_h;
    logic            restart, q_valid, q_ready, w_valid, w_ready;
    logic            f_valid, f_ready, f_last;
    logic [7:0]      f_red, f_green, f_blue;
    logic [20:0]     f_sr, f_sg, f_sb;
    fe_word_t        q_word;
    win_word_t       w_word;

    assign restart = cfg_we;
    assign eff_w = (lw_reg == '0) ? (ColW+1)'(1) :
                   (lw_reg > LwW'(MaxWidth)) ? (ColW+1)'(MaxWidth) : lw_reg;
    assign eff_h = (fh_reg == '0) ? RowW'(1) :
                   (fh_reg > FhW'(MaxHeight)) ? RowW'(MaxHeight) : fh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_reg <= LwW'(MaxWidth);
            fh_reg <= FhW'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                RegLineWidth:   lw_reg <= cfg_data[LwW-1:0];
                RegFrameHeight: fh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sobel_front u_front (
        .aclk, .aresetn, .restart, .eff_h, .eff_w,
        .s_valid, .s_ready, .s_req_type, .s_red_in, .s_green_in, .s_blue_in,
        .q_valid, .q_ready, .q_word
    );

    sobel_window u_window (
        .aclk, .aresetn, .restart, .eff_h, .eff_w,
        .q_valid, .q_ready, .q_word,
        .w_valid, .w_ready, .w_word
    );

    sobel_mag u_mag (
        .aclk, .aresetn, .restart, .w_valid, .w_ready, .w_word,
        .f_valid, .f_ready, .f_red, .f_green, .f_blue,
        .f_sr, .f_sg, .f_sb, .f_last
    );

    sobel_round u_round (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready),
        .in_r(f_red), .in_g(f_green), .in_b(f_blue),
        .in_sr(f_sr), .in_sg(f_sg), .in_sb(f_sb), .in_last(f_last),
        .m_valid, .m_ready, .m_red_out, .m_green_out, .m_blue_out, .m_last_pixel
    );
endmodule

### test/tb_sobel_edge_magnitude_rgb_top.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Drives RGB frames, drain words and stray words through the block. A
// predictor with its own line stores and window works out every result, and
// the monitor compares each output word with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_rgb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sobel_pkg::*;

    typedef enum logic {REQ_PIXEL = 1'b0, REQ_DRAIN = 1'b1} req_e;

    typedef struct {
        req_e       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_word_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } edge_word_t;

    localparam int WatchdogLimit = 20000;
    localparam int SettleCycles  = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = 1'b0;
    logic [7:0]  s_red_in = '0;
    logic [7:0]  s_green_in = '0;
    logic [7:0]  s_blue_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_red_out;
    logic [7:0]  m_green_out;
    logic [7:0]  m_blue_out;
    logic        m_last_pixel;

    sobel_edge_magnitude_rgb_top uut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    pixel_word_t pending_words[$];
    edge_word_t  expected_edges[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;

    // Predictor state.
    int          width_reg = 1024;
    int          height_reg = 1;
    logic [23:0] upper_row[MaxWidth];
    logic [23:0] lower_row[MaxWidth];
    logic [23:0] win[9];
    int          in_col, in_row, out_col, out_row;

    function automatic int eff_width();
        return width_reg < 1 ? 1 : (width_reg > MaxWidth ? MaxWidth : width_reg);
    endfunction

    function automatic int eff_height();
        return height_reg < 1 ? 1 : (height_reg > MaxHeight ? MaxHeight : height_reg);
    endfunction

    function automatic void restart_frame();
        foreach (win[i]) win[i] = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic logic [7:0] channel_magnitude(int sh, logic [8:0] mask);
        int gx, gy, v, s, root;
        int kx[9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
        int ky[9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
        gx = 0;
        gy = 0;
        for (int k = 0; k < 9; k++) begin
            if (mask[k]) begin
                v = (win[k] >> sh) & 8'hFF;
                gx += v * kx[k];
                gy += v * ky[k];
            end
        end
        s = gx * gx + gy * gy;
        if (s > 65280) return 8'd255;
        root = 0;
        while ((root + 1) * (root + 1) <= s) root++;
        if (s > root * root + root) root++;
        return root > 255 ? 8'd255 : root[7:0];
    endfunction

    function automatic void predict_edges(pixel_word_t pw);
        int          w, h, c, r;
        logic [23:0] pix, up, lo;
        logic [8:0]  mask;
        edge_word_t  ew;
        w = eff_width();
        h = eff_height();
        if ((pw.kind == REQ_PIXEL) == (in_row >= h)) return;
        pix = (pw.kind == REQ_PIXEL) ? {pw.red, pw.green, pw.blue} : 24'd0;
        c = in_col;
        r = in_row;
        up = upper_row[c];
        lo = lower_row[c];
        upper_row[c] = lo;
        lower_row[c] = pix;
        for (int i = 0; i < 3; i++) begin
            win[i*3] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = up;
        win[5] = lo;
        win[8] = pix;
        if (c + 1 >= w) begin
            in_col = 0;
            in_row = r + 1;
        end else begin
            in_col = c + 1;
        end
        if (!(r >= 2 || (r == 1 && c >= 1))) return;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                mask[i*3+j] = !((i == 0 && out_row == 0) || (i == 2 && out_row + 1 >= h) ||
                                (j == 0 && out_col == 0) || (j == 2 && out_col + 1 >= w));
            end
        end
        ew.red = channel_magnitude(16, mask);
        ew.green = channel_magnitude(8, mask);
        ew.blue = channel_magnitude(0, mask);
        ew.last = (out_row + 1 >= h) && (out_col + 1 >= w);
        expected_edges.push_back(ew);
        if (ew.last) begin
            restart_frame();
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endfunction

    // Driver: holds each word until it is taken, then pulls the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_edges('{req_e'(s_req_type), s_red_in, s_green_in, s_blue_in});
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    pixel_word_t pw;
                    pw = pending_words.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= pw.kind;
                    s_red_in <= pw.red;
                    s_green_in <= pw.green;
                    s_blue_in <= pw.blue;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_edges.size() == 0) begin
                    $error("unexpected output word: red %0d green %0d blue %0d last %0d",
                           m_red_out, m_green_out, m_blue_out, m_last_pixel);
                    errors++;
                end else begin
                    edge_word_t ew;
                    ew = expected_edges.pop_front();
                    if (m_red_out !== ew.red) begin
                        $error("red_out: expected %0d, got %0d", ew.red, m_red_out);
                        errors++;
                    end
                    if (m_green_out !== ew.green) begin
                        $error("green_out: expected %0d, got %0d", ew.green, m_green_out);
                        errors++;
                    end
                    if (m_blue_out !== ew.blue) begin
                        $error("blue_out: expected %0d, got %0d", ew.blue, m_blue_out);
                        errors++;
                    end
                    if (m_last_pixel !== ew.last) begin
                        $error("last_pixel: expected %0d, got %0d", ew.last, m_last_pixel);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] pick_level();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pending_words.push_back('{REQ_PIXEL, r, g, b});
    endfunction

    function automatic void push_drain();
        pending_words.push_back('{REQ_DRAIN, 8'($urandom_range(255)),
                                  8'($urandom_range(255)), 8'($urandom_range(255))});
    endfunction

    // One frame of random content; with noise, stray words that the block ignores.
    function automatic void push_frame(int w, int h, bit noise);
        for (int i = 0; i < w * h; i++) begin
            if (noise && $urandom_range(15) == 0) push_drain();
            push_pixel(pick_level(), pick_level(), pick_level());
        end
        if (noise && $urandom_range(1)) begin
            push_pixel(pick_level(), pick_level(), pick_level());
        end
        for (int i = 0; i <= w; i++) push_drain();
    endfunction

    task automatic wait_idle();
        wait (pending_words.size() == 0 && !s_valid && expected_edges.size() == 0);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, int value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[12:0];
        if (idx == RegLineWidth) width_reg = value & 11'h7FF;
        else height_reg = value & 13'h1FFF;
        restart_frame();
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int w, h, queued;
        foreach (upper_row[i]) begin
            upper_row[i] = '0;
            lower_row[i] = '0;
        end
        restart_frame();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: 3x3 frame with extreme and checkerboard content.
        write_reg(RegLineWidth, 3);
        write_reg(RegFrameHeight, 3);
        push_drain();
        for (int i = 0; i < 9; i++) begin
            if (i % 2) push_pixel(8'd255, 8'd0, 8'd255);
            else push_pixel(8'd0, 8'd255, 8'd0);
        end
        push_pixel(8'd255, 8'd255, 8'd255);
        for (int i = 0; i < 4; i++) push_drain();
        push_drain();
        wait_idle();

        // One-row frame, sender pausing halfway until all results are out.
        write_reg(RegFrameHeight, 1);
        write_reg(RegLineWidth, 4);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd0, 8'd0, 8'd0);
        wait_idle();
        push_pixel(8'd255, 8'd0, 8'd0);
        push_pixel(8'd0, 8'd255, 8'd255);
        for (int i = 0; i < 5; i++) push_drain();
        wait_idle();

        // Clamped register values.
        write_reg(RegLineWidth, 0);
        write_reg(RegFrameHeight, 0);
        push_frame(1, 1, 0);
        wait_idle();

        // Random frames under each idling phase.
        queued = 0;
        for (int ph = 0; queued < 680; ph++) begin
            case (ph % 5)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                3: begin send_idle_pct = 17; recv_stall_pct = 17; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            write_reg(RegLineWidth, w);
            write_reg(RegFrameHeight, h);
            for (int f = 0; f < 2; f++) begin
                push_frame(w, h, 1);
                queued += w * h + w + 1;
            end
            wait_idle();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_idle();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
